>>> rtl/core/gls_pkg.sv
// package of shared types, sizes and codes for the gas level smoother
`timescale 1ns / 1ps

package gls_pkg;

    // window geometry
    localparam int WINDOW     = 10;
    localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    // field widths
    localparam int SAMPLE_W   = 12;
    localparam int LEVEL_W    = 7;
    localparam int DUTY_W     = 8;
    localparam int CLASS_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // scaling to 0..100
    localparam int FULL_SCALE = 4095;
    localparam int LEVEL_SPAN = 100;
    localparam int SCALED_W   = SAMPLE_W + LEVEL_W;

    // running sum and exact divide by WINDOW via rounded-up reciprocal
    localparam int     SUM_W     = $clog2(WINDOW * LEVEL_SPAN + 1);
    localparam int     DIV_SHIFT = SUM_W + $clog2(WINDOW);
    localparam longint DIV_RECIP = ((longint'(1) << DIV_SHIFT) + WINDOW - 1) / WINDOW;
    localparam int     RECIP_W   = DIV_SHIFT + 1;
    localparam int     PROD_W    = SUM_W + RECIP_W;

    // class codes, also used as buzzer codes
    localparam logic [CLASS_W-1:0] CLS_SAFE     = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_WARNING  = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_CRITICAL = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARN_LEVEL        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL_LEVEL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WARN_FAN_DUTY     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL_FAN_DUTY = 3'd4;

    // register reset values
    localparam logic [SAMPLE_W-1:0] RST_ZERO_OFFSET       = 12'd0;
    localparam logic [LEVEL_W-1:0]  RST_WARN_LEVEL        = 7'd40;
    localparam logic [LEVEL_W-1:0]  RST_CRITICAL_LEVEL    = 7'd45;
    localparam logic [DUTY_W-1:0]   RST_WARN_FAN_DUTY     = 8'd77;
    localparam logic [DUTY_W-1:0]   RST_CRITICAL_FAN_DUTY = 8'd255;

    typedef struct packed {
        logic               en;
        logic [SLOT_W-1:0]  slot;
    } t_ring_rd;

    typedef struct packed {
        logic               en;
        logic [SLOT_W-1:0]  slot;
        logic [LEVEL_W-1:0] data;
    } t_ring_wr;

    typedef struct packed {
        logic [LEVEL_W-1:0] warn_level;
        logic [LEVEL_W-1:0] critical_level;
        logic [DUTY_W-1:0]  warn_fan_duty;
        logic [DUTY_W-1:0]  critical_fan_duty;
    } t_thresholds;

    typedef struct packed {
        logic [LEVEL_W-1:0] average_level;
        logic [CLASS_W-1:0] level_class;
        logic               valve_close;
        logic [DUTY_W-1:0]  fan_duty;
        logic               lamp_green;
        logic               lamp_yellow;
        logic               lamp_red;
        logic               lamp_valve_status;
        logic [CLASS_W-1:0] buzzer_mode;
        logic               hazard_event;
    } t_result;

endpackage

>>> rtl/core/gls_ifs.sv
// valid/ready channel interfaces for samples, results and register writes
`timescale 1ns / 1ps

interface gls_in_if;
    logic                          valid;
    logic                          ready;
    logic [gls_pkg::SAMPLE_W-1:0]  raw_sample;

    modport source (output valid, output raw_sample, input ready);
    modport sink   (input valid, input raw_sample, output ready);
endinterface

interface gls_out_if;
    logic                          valid;
    logic                          ready;
    logic [gls_pkg::LEVEL_W-1:0]   average_level;
    logic [gls_pkg::CLASS_W-1:0]   level_class;
    logic                          valve_close;
    logic [gls_pkg::DUTY_W-1:0]    fan_duty;
    logic                          lamp_green;
    logic                          lamp_yellow;
    logic                          lamp_red;
    logic                          lamp_valve_status;
    logic [gls_pkg::CLASS_W-1:0]   buzzer_mode;
    logic                          hazard_event;

    modport source (
        output valid, output average_level, output level_class, output valve_close,
        output fan_duty, output lamp_green, output lamp_yellow, output lamp_red,
        output lamp_valve_status, output buzzer_mode, output hazard_event,
        input ready
    );
    modport sink (
        input valid, input average_level, input level_class, input valve_close,
        input fan_duty, input lamp_green, input lamp_yellow, input lamp_red,
        input lamp_valve_status, input buzzer_mode, input hazard_event,
        output ready
    );
endinterface

interface gls_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [gls_pkg::CFG_IDX_W-1:0]   index;
    logic [gls_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/gls_ring.sv
// sample ring memory with per-slot valid bits and same-slot forwarding
`timescale 1ns / 1ps

module gls_ring (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  gls_pkg::t_ring_rd         i_rd,
    input  gls_pkg::t_ring_wr         i_wr,
    output logic [gls_pkg::LEVEL_W-1:0] o_old_value
);
    import gls_pkg::*;

    logic [LEVEL_W-1:0] mem [WINDOW];
    logic [WINDOW-1:0]  r_valid;
    logic [LEVEL_W-1:0] r_rd_data;
    logic               r_rd_valid;
    logic               r_fwd;
    logic [LEVEL_W-1:0] r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.slot] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data  <= mem[i_rd.slot];
            r_fwd_data <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.slot] <= 1'b1;
            end
            if (i_rd.en) begin
                r_rd_valid <= r_valid[i_rd.slot];
                // write to the slot being read in the same cycle
                r_fwd      <= i_wr.en && (i_wr.slot == i_rd.slot);
            end
        end
    end

    assign o_old_value = r_fwd      ? r_fwd_data :
                         r_rd_valid ? r_rd_data  : '0;

endmodule

>>> rtl/core/gls_classify.sv
// level classification, actuator decode and hazard one-shot state
`timescale 1ns / 1ps

module gls_classify (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic [gls_pkg::LEVEL_W-1:0] i_level,
    input  gls_pkg::t_thresholds        i_thr,
    output gls_pkg::t_result            o_result
);
    import gls_pkg::*;

    logic               r_hazard;
    logic               n_hazard;
    logic [CLASS_W-1:0] cls;
    logic [DUTY_W-1:0]  duty;
    logic               event_hit;

    always_comb begin
        n_hazard  = r_hazard;
        event_hit = 1'b0;
        priority if (i_level < i_thr.warn_level) begin
            cls      = CLS_SAFE;
            duty     = '0;
            n_hazard = 1'b0;
        end else if (i_level < i_thr.critical_level) begin
            cls  = CLS_WARNING;
            duty = i_thr.warn_fan_duty;
        end else begin
            cls       = CLS_CRITICAL;
            duty      = i_thr.critical_fan_duty;
            event_hit = !r_hazard;
            n_hazard  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hazard <= 1'b0;
        end else if (i_load) begin
            r_hazard <= n_hazard;
        end
    end

    always_comb begin
        o_result.average_level     = i_level;
        o_result.level_class       = cls;
        o_result.valve_close       = (cls == CLS_CRITICAL);
        o_result.fan_duty          = duty;
        o_result.lamp_green        = (cls == CLS_SAFE);
        o_result.lamp_yellow       = (cls == CLS_WARNING);
        o_result.lamp_red          = (cls == CLS_CRITICAL);
        o_result.lamp_valve_status = (cls == CLS_CRITICAL);
        o_result.buzzer_mode       = cls;
        o_result.hazard_event      = event_hit;
    end

endmodule

>>> rtl/core/gas_level_smoother_classifier.sv
// top level of the gas level smoother and classifier
`timescale 1ns / 1ps

// usage
// - i_in carries one raw 12-bit gas sample per word, o_out one result word per
//   sample (average level, class, valve, fan duty, lamps, buzzer, hazard pulse)
// - i_cfg writes one register per word; it is always ready; the user must only write
//   it while no sample is in flight, and the block itself does not enforce this
// - four-stage pipeline: each accepted sample passes in turn through the scaled,
//   sum, level and output registers before o_out presents its result
// - throughput is one sample per cycle while o_out.ready is high; each stage
//   holds one word and the ring memory is read at accept and written one stage
//   later, so consecutive samples never wait on each other
// - a stalled receiver holds the output register; stages behind it keep
//   filling until the pipeline is full, then i_in.ready drops
// - reset clears the ring valid bits (empty slots read as zero), the write
//   slot, the running sum, the hazard flag and the configuration registers to
//   their default values; the block is ready as soon as reset is released

module gas_level_smoother_classifier (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gls_in_if.sink    i_in,
    gls_out_if.source o_out,
    gls_cfg_if.sink   i_cfg
);
    import gls_pkg::*;

    // configuration registers
    logic [SAMPLE_W-1:0] r_zero_offset;
    t_thresholds         r_thr;

    // pipeline valids
    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;
    logic accept, mv1, mv2, mv3;

    // stage 0: offset removal and scale to 0..100
    logic [SAMPLE_W-1:0] diff;
    logic [SCALED_W-1:0] scaled_prod;
    logic [LEVEL_W-1:0]  q_lo;
    logic [SAMPLE_W:0]   q_rem;
    logic [LEVEL_W-1:0]  n_scaled;

    // ring slot and stage registers
    logic [SLOT_W-1:0]   r_slot;
    logic [SLOT_W-1:0]   r_slot1;
    logic [LEVEL_W-1:0]  r_scaled1;
    logic [SUM_W-1:0]    r_sum;
    logic [SUM_W-1:0]    n_sum;
    logic [SUM_W-1:0]    r_sum2;
    logic [PROD_W-1:0]   div_prod;
    logic [LEVEL_W-1:0]  r_level3;
    t_result             r_out;
    t_result             n_out;

    t_ring_rd            ring_rd;
    t_ring_wr            ring_wr;
    logic [LEVEL_W-1:0]  old_value;

    // handshakes, each stage moves when the next one is free or moving
    assign rdy4   = !r_v4 || o_out.ready;
    assign rdy3   = !r_v3 || rdy4;
    assign rdy2   = !r_v2 || rdy3;
    assign rdy1   = !r_v1 || rdy2;
    assign accept = i_in.valid && rdy1;
    assign mv1    = r_v1 && rdy2;
    assign mv2    = r_v2 && rdy3;
    assign mv3    = r_v3 && rdy4;

    assign i_in.ready  = rdy1;
    assign i_cfg.ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_offset         <= RST_ZERO_OFFSET;
            r_thr.warn_level        <= RST_WARN_LEVEL;
            r_thr.critical_level    <= RST_CRITICAL_LEVEL;
            r_thr.warn_fan_duty     <= RST_WARN_FAN_DUTY;
            r_thr.critical_fan_duty <= RST_CRITICAL_FAN_DUTY;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_ZERO_OFFSET:       r_zero_offset <= i_cfg.data[SAMPLE_W-1:0];
                CFG_WARN_LEVEL:        r_thr.warn_level <= i_cfg.data[LEVEL_W-1:0];
                CFG_CRITICAL_LEVEL:    r_thr.critical_level <= i_cfg.data[LEVEL_W-1:0];
                CFG_WARN_FAN_DUTY:     r_thr.warn_fan_duty <= i_cfg.data[DUTY_W-1:0];
                CFG_CRITICAL_FAN_DUTY: r_thr.critical_fan_duty <= i_cfg.data[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    // x*100/4095: take x*100/4096, then one correction since the
    // remainder against 4095 stays below twice the divisor
    always_comb begin
        diff        = (i_in.raw_sample > r_zero_offset) ?
                      (i_in.raw_sample - r_zero_offset) : '0;
        scaled_prod = SCALED_W'(diff) * SCALED_W'(LEVEL_SPAN);
        q_lo        = scaled_prod[SCALED_W-1:SAMPLE_W];
        q_rem       = {1'b0, scaled_prod[SAMPLE_W-1:0]} + (SAMPLE_W+1)'(q_lo);
        n_scaled    = (q_rem >= (SAMPLE_W+1)'(FULL_SCALE)) ? (q_lo + 1'b1) : q_lo;
    end

    // ring memory: read the slot at accept, write it back one stage later
    assign ring_rd.en   = accept;
    assign ring_rd.slot = r_slot;
    assign ring_wr.en   = mv1;
    assign ring_wr.slot = r_slot1;
    assign ring_wr.data = r_scaled1;

    gls_ring u_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd        (ring_rd),
        .i_wr        (ring_wr),
        .o_old_value (old_value)
    );

    // drop the oldest sample, add the new one
    assign n_sum = r_sum - SUM_W'(old_value) + SUM_W'(r_scaled1);

    // floor(sum / WINDOW) through an exact reciprocal multiply
    assign div_prod = PROD_W'(r_sum2) * PROD_W'(DIV_RECIP);

    gls_classify u_classify (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (mv3),
        .i_level  (r_level3),
        .i_thr    (r_thr),
        .o_result (n_out)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_slot <= '0;
            r_sum  <= '0;
        end else begin
            if (rdy1) r_v1 <= i_in.valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (accept) begin
                r_slot <= (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : (r_slot + 1'b1);
            end
            if (mv1) r_sum <= n_sum;
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_scaled1 <= n_scaled;
            r_slot1   <= r_slot;
        end
        if (mv1) r_sum2   <= n_sum;
        if (mv2) r_level3 <= div_prod[DIV_SHIFT +: LEVEL_W];
        if (mv3) r_out    <= n_out;
    end

    assign o_out.valid             = r_v4;
    assign o_out.average_level     = r_out.average_level;
    assign o_out.level_class       = r_out.level_class;
    assign o_out.valve_close       = r_out.valve_close;
    assign o_out.fan_duty          = r_out.fan_duty;
    assign o_out.lamp_green        = r_out.lamp_green;
    assign o_out.lamp_yellow       = r_out.lamp_yellow;
    assign o_out.lamp_red          = r_out.lamp_red;
    assign o_out.lamp_valve_status = r_out.lamp_valve_status;
    assign o_out.buzzer_mode       = r_out.buzzer_mode;
    assign o_out.hazard_event      = r_out.hazard_event;

endmodule
